@@ hdl/ipdm_pkg.sv @@
// ============================================================================
// IPD frame matcher package
// Shared types, character constants and helpers for the "+IPD,<id>,<len>:"
// frame matcher.
// ============================================================================
package ipdm_pkg;

    // Default number of payload bytes a frame may carry
    localparam int DEFAULT_PAYLOAD_CAPACITY = 512;

    // Field widths of the result beat, and the length of the lead text
    localparam int STATUS_W     = 2;
    localparam int CONN_W       = 3;
    localparam int LENGTH_W     = 16;
    localparam int BYTE_W       = 8;
    localparam int DATA_INDEX_W = 9;
    localparam int PREFIX_LEN   = 5;

    // Characters the matcher looks for
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_FOUR  = 8'h34;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_UP_I  = 8'h49;
    localparam logic [BYTE_W-1:0] CH_UP_P  = 8'h50;
    localparam logic [BYTE_W-1:0] CH_UP_D  = 8'h44;

    // Largest value the length accumulator holds
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = 16'hFFFF;

    // Matcher phases
    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_ID      = 3'd1,
        PH_COMMA   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // Per-byte match status
    typedef enum logic [STATUS_W-1:0] {
        ST_NONE       = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_COMPLETE   = 2'd2
    } t_status;

    // One result beat as produced by the parser
    typedef struct packed {
        t_status                   status;
        logic [CONN_W-1:0]         conn_id;
        logic [LENGTH_W-1:0]       frame_length;
        logic                      data_valid;
        logic [BYTE_W-1:0]         data_byte;
        logic [DATA_INDEX_W-1:0]   data_index;
    } t_result;

    // Expected character at each position of the "+IPD," lead text
    function automatic logic [BYTE_W-1:0] lead_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] ch;
        unique case (pos)
            3'd0:    ch = CH_PLUS;
            3'd1:    ch = CH_UP_I;
            3'd2:    ch = CH_UP_P;
            3'd3:    ch = CH_UP_D;
            3'd4:    ch = CH_COMMA;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

@@ hdl/ipdm_parser.sv @@
// ============================================================================
// IPD frame parser
// Holds the matcher state and works out the result for each received byte in
// a single pass of combinational logic.
// ============================================================================
module ipdm_parser #(
    parameter int PAYLOAD_CAPACITY = ipdm_pkg::DEFAULT_PAYLOAD_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_rx_byte,
    output ipdm_pkg::t_result o_result
);
    import ipdm_pkg::*;

    localparam int CW = $clog2(PAYLOAD_CAPACITY + 1);
    localparam logic [CW-1:0] CAPACITY = CW'(PAYLOAD_CAPACITY);

    t_phase              r_phase,       n_phase;
    logic [2:0]          r_prefix_pos,  n_prefix_pos;
    logic [CONN_W-1:0]   r_held_conn,   n_held_conn;
    logic [LENGTH_W-1:0] r_length_acc,  n_length_acc;
    logic [CW-1:0]       r_write_count, n_write_count;

    t_status             status;
    logic                dvalid;
    logic                is_digit;
    logic [3:0]          digit;
    logic [19:0]         length_next;
    logic [CW-1:0]       count_inc;
    logic [CW+DATA_INDEX_W-1:0] index_wide;

    // Helpers for the length and payload arithmetic
    assign is_digit    = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit       = 4'(i_rx_byte - CH_ZERO);
    assign length_next = ({4'b0, r_length_acc} << 3) + ({4'b0, r_length_acc} << 1)
                         + {16'b0, digit};
    assign count_inc   = r_write_count + CW'(1);
    assign index_wide  = {{DATA_INDEX_W{1'b0}}, r_write_count};

    // Next state and result for the byte on the input
    always_comb begin
        n_phase       = r_phase;
        n_prefix_pos  = r_prefix_pos;
        n_held_conn   = r_held_conn;
        n_length_acc  = r_length_acc;
        n_write_count = r_write_count;
        status        = ST_NONE;
        dvalid        = 1'b0;

        unique case (r_phase)
            PH_PREFIX: begin
                if (r_prefix_pos < 3'(PREFIX_LEN) && i_rx_byte == lead_char(r_prefix_pos)) begin
                    n_prefix_pos = r_prefix_pos + 3'd1;
                    status       = ST_INCOMPLETE;
                    if (r_prefix_pos == 3'(PREFIX_LEN - 1)) begin
                        n_phase = PH_ID;
                    end
                end
            end
            PH_ID: begin
                if (i_rx_byte >= CH_ZERO && i_rx_byte <= CH_FOUR) begin
                    n_held_conn = digit[CONN_W-1:0];
                    n_phase     = PH_COMMA;
                    status      = ST_INCOMPLETE;
                end
            end
            PH_COMMA: begin
                if (i_rx_byte == CH_COMMA) begin
                    n_length_acc = '0;
                    n_phase      = PH_LENGTH;
                    status       = ST_INCOMPLETE;
                end
            end
            PH_LENGTH: begin
                if (i_rx_byte == CH_COLON && r_length_acc != '0) begin
                    n_phase = PH_PAYLOAD;
                    status  = ST_INCOMPLETE;
                end else if (is_digit) begin
                    n_length_acc = (length_next > {4'b0, LENGTH_MAX}) ? LENGTH_MAX
                                                                      : length_next[15:0];
                    status       = ST_INCOMPLETE;
                end
            end
            PH_PAYLOAD: begin
                if (r_write_count < CAPACITY) begin
                    dvalid        = 1'b1;
                    n_write_count = count_inc;
                    status = ({{(17-CW){1'b0}}, count_inc} == {1'b0, r_length_acc})
                             ? ST_COMPLETE : ST_INCOMPLETE;
                end
            end
            default: begin
                status = ST_NONE;
            end
        endcase

        // Any outcome other than incomplete restarts the search
        if (status != ST_INCOMPLETE) begin
            n_phase       = PH_PREFIX;
            n_prefix_pos  = '0;
            n_write_count = '0;
        end
    end

    // Result as seen after this byte
    always_comb begin
        o_result.status       = status;
        o_result.conn_id      = n_held_conn;
        o_result.frame_length = n_length_acc;
        o_result.data_valid   = dvalid;
        o_result.data_byte    = dvalid ? i_rx_byte : '0;
        o_result.data_index   = dvalid ? index_wide[DATA_INDEX_W-1:0] : '0;
    end

    // State register, stepped once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_PREFIX;
            r_prefix_pos  <= '0;
            r_held_conn   <= '0;
            r_length_acc  <= '0;
            r_write_count <= '0;
        end else if (i_advance) begin
            r_phase       <= n_phase;
            r_prefix_pos  <= n_prefix_pos;
            r_held_conn   <= n_held_conn;
            r_length_acc  <= n_length_acc;
            r_write_count <= n_write_count;
        end
    end

`ifndef NO_ASSERTIONS
    // A payload byte is only reported while in the payload phase
    a_dvalid_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.data_valid |-> r_phase == PH_PAYLOAD)
        else $error("payload byte reported outside payload phase");

    // A completed frame always ends on a payload byte
    a_complete_dvalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.status == ST_COMPLETE) |-> o_result.data_valid)
        else $error("frame completed without a payload byte");

    // No match or completion returns the matcher to its start
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && status != ST_INCOMPLETE) |=>
            (r_phase == PH_PREFIX && r_prefix_pos == '0 && r_write_count == '0))
        else $error("matcher did not restart");

    // The payload count never passes the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_count <= CAPACITY)
        else $error("payload count above capacity");
`endif

endmodule

@@ hdl/ipd_frame_matcher_core.sv @@
// A result beat appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register is refilled in the cycle it is taken.
// The slave side stalls only while a result beat waits and the master side is not ready.
// Reset (i_rst_n low, synchronous) returns the matcher to the start of the lead text,
// clears the held connection id, length and payload count, and empties the output register.
// ============================================================================
// IPD frame matcher core
// Streaming wrapper: accepts one received byte per beat, runs the parser and
// holds each result beat in an output register until the master side takes it.
// ============================================================================
module ipd_frame_matcher_core #(
    parameter int PAYLOAD_CAPACITY = ipdm_pkg::DEFAULT_PAYLOAD_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: received characters
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Master side: match results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [1:0] match_status, [4:2] conn_id,
                                     // [20:5] frame_length, [28:21] data_byte,
                                     // [37:29] data_index, [39:38] zero
    output logic        o_m_tuser    // [0] data_valid
);
    import ipdm_pkg::*;

    t_result parse_result;
    t_result r_result;
    logic    r_m_valid;
    logic    advance;

    // Accept a new byte whenever the output register is free or being emptied
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign advance    = i_s_tvalid && o_s_tready;

    ipdm_parser #(
        .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_rx_byte (i_s_tdata),
        .o_result  (parse_result)
    );

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_m_valid <= i_s_tvalid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= parse_result;
        end
    end

    // Pack the result beat
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00,
                         r_result.data_index,
                         r_result.data_byte,
                         r_result.frame_length,
                         r_result.conn_id,
                         r_result.status};
    assign o_m_tuser  = r_result.data_valid;

endmodule

@@ verif/ipd_frame_matcher_core_tb.sv @@
// ============================================================================
// IPD frame matcher core testbench
// Sends received characters into the matcher and checks every result beat,
// field by field, against a cycle-free model of the "+IPD,<id>,<len>:" parser.
// The sender works in random bursts and gaps, and the receiver stalls on a
// pattern of its own. A short directed sequence covers saturation and a
// zero length. Mostly well-formed frames with random content then follow,
// mixed with noise and broken frames.
// ============================================================================
module ipd_frame_matcher_core_tb;

    import ipdm_pkg::*;

    localparam int PAYLOAD_CAP    = DEFAULT_PAYLOAD_CAPACITY;
    localparam int RX_ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 16;

    // One received character, optionally held back until the matcher is drained
    typedef struct {
        logic [BYTE_W-1:0] ch;
        bit                hold_for_drain;
    } t_rx_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;

    t_rx_char rx_backlog[$];
    t_result  pending_results[$];
    int       error_count = 0;
    int       cycle_count = 0;

    // Model state of the parser
    t_phase                 cur_phase = PH_PREFIX;
    logic [2:0]             lead_pos = '0;
    logic [CONN_W-1:0]      last_conn = '0;
    logic [LENGTH_W-1:0]    len_acc = '0;
    logic [9:0]             payload_count = '0;

    logic [BYTE_W-1:0] ipd_lead [PREFIX_LEN] = '{CH_PLUS, CH_UP_I, CH_UP_P, CH_UP_D, CH_COMMA};

    // Sender and receiver pacing
    int burst_left = 0;
    int gap_left = 0;
    int ready_left = 0;
    int stall_left = 0;

    ipd_frame_matcher_core #(
        .PAYLOAD_CAPACITY(PAYLOAD_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Reset is held at the start and never raised again.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Advance the parser model by one received character and return its beat.
    function automatic t_result parse_rx_byte(input logic [BYTE_W-1:0] c);
        t_result     r;
        int unsigned acc;
        r = '0;
        r.status = ST_NONE;
        case (cur_phase)
            PH_PREFIX: begin
                if (lead_pos < PREFIX_LEN && c == ipd_lead[lead_pos]) begin
                    lead_pos = lead_pos + 3'd1;
                    r.status = ST_INCOMPLETE;
                    if (lead_pos == PREFIX_LEN)
                        cur_phase = PH_ID;
                end
            end
            PH_ID: begin
                if (c >= CH_ZERO && c <= CH_FOUR) begin
                    last_conn = CONN_W'(c - CH_ZERO);
                    cur_phase = PH_COMMA;
                    r.status = ST_INCOMPLETE;
                end
            end
            PH_COMMA: begin
                if (c == CH_COMMA) begin
                    len_acc = '0;
                    cur_phase = PH_LENGTH;
                    r.status = ST_INCOMPLETE;
                end
            end
            PH_LENGTH: begin
                if (c == CH_COLON && len_acc != 0) begin
                    cur_phase = PH_PAYLOAD;
                    r.status = ST_INCOMPLETE;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    // Decimal accumulation, saturating at the top of the field.
                    acc = 32'(len_acc) * 10 + 32'(c) - 32'(CH_ZERO);
                    len_acc = (acc > 32'(LENGTH_MAX)) ? LENGTH_MAX : acc[LENGTH_W-1:0];
                    r.status = ST_INCOMPLETE;
                end
            end
            PH_PAYLOAD: begin
                if (payload_count < PAYLOAD_CAP) begin
                    r.data_valid = 1'b1;
                    r.data_byte = c;
                    r.data_index = payload_count[DATA_INDEX_W-1:0];
                    payload_count = payload_count + 10'd1;
                    r.status = (32'(payload_count) == 32'(len_acc)) ? ST_COMPLETE
                                                                    : ST_INCOMPLETE;
                end
            end
            default: ;
        endcase
        // Anything but an incomplete match sends the parser back to the lead text.
        if (r.status != ST_INCOMPLETE) begin
            cur_phase = PH_PREFIX;
            lead_pos = '0;
            payload_count = '0;
        end
        r.conn_id = last_conn;
        r.frame_length = len_acc;
        return r;
    endfunction

    function automatic void queue_char(input logic [BYTE_W-1:0] ch, input bit drain = 1'b0);
        t_rx_char item;
        item.ch = ch;
        item.hold_for_drain = drain;
        rx_backlog.push_back(item);
    endfunction

    function automatic void queue_text(input string s, input bit drain = 1'b0);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], drain && i == 0);
    endfunction

    function automatic void queue_payload(input int n);
        for (int i = 0; i < n; i++)
            queue_char(8'($urandom_range(0, 255)));
    endfunction

    // Header of a frame, sometimes with a leading zero on the length.
    function automatic string frame_header(input int id, input int len_val);
        string lead_zero;
        lead_zero = "";
        if ($urandom_range(0, 9) == 0)
            lead_zero = "0";
        return $sformatf("+IPD,%0d,%s%0d:", id, lead_zero, len_val);
    endfunction

    // One random piece of traffic: mostly frames, some noise and broken frames.
    function automatic void queue_random_segment(input bit drain);
        int    pick;
        int    len_val;
        int    cut;
        string hdr;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            len_val = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                  : $urandom_range(1, 24);
            queue_text(frame_header($urandom_range(0, 4), len_val), drain);
            // Occasionally the payload is cut short and the next bytes run into it.
            if ($urandom_range(0, 9) == 0)
                queue_payload($urandom_range(0, len_val - 1));
            else
                queue_payload(len_val);
        end else if (pick < 70) begin
            for (int i = $urandom_range(1, 6); i > 0; i--)
                queue_char(($urandom_range(0, 3) == 0) ? CH_PLUS : 8'($urandom_range(0, 255)),
                           drain && i == 1);
        end else if (pick < 85) begin
            hdr = frame_header($urandom_range(0, 4), $urandom_range(1, 999));
            cut = $urandom_range(0, hdr.len() - 1);
            queue_text(hdr.substr(0, cut - 1), drain);
            queue_char(8'($urandom_range(0, 255)));
        end else if (pick < 92) begin
            queue_text("+IPD,", drain);
            queue_char(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h35, 8'h39))
                                                   : 8'($urandom_range(0, 255)));
            queue_text(",3:x");
        end else begin
            queue_text($sformatf("+IPD,%0d,", $urandom_range(0, 4)), drain);
            for (int i = $urandom_range(0, 3); i > 0; i--)
                queue_char(CH_ZERO);
            queue_char(CH_COLON);
        end
    endfunction

    // Stimulus: directed frames first, then random traffic.
    initial begin
        bit capacity_done;
        capacity_done = 1'b0;
        // A zero length, then a saturating length with the highest id. The long
        // frame keeps taking payload bytes until it reaches the capacity.
        queue_text("+IPD,0,0:");
        queue_char(8'h00);
        queue_text("+IPD,4,70000:");
        queue_char(8'hFF);
        // Random traffic; the first segment waits until the directed part has drained.
        queue_random_segment(1'b1);
        while (rx_backlog.size() < RX_ITEM_TARGET) begin
            if (!capacity_done && rx_backlog.size() > 600) begin
                // A frame longer than the payload capacity is cut off at its limit.
                queue_text("+IPD,2,513:");
                queue_payload(PAYLOAD_CAP + 1);
                capacity_done = 1'b1;
            end
            queue_random_segment($urandom_range(0, 29) == 0);
        end

        while (rx_backlog.size() != 0 || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("** ipd_frame_matcher_core: PASSED **");
        else
            $display("** ipd_frame_matcher_core: FAILED **");
        $finish;
    end

    // Sender: presents characters in bursts and predicts each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pending_results.push_back(parse_rx_byte(i_s_tdata));
                void'(rx_backlog.pop_front());
            end
            if (i_s_tvalid && !o_s_tready) begin
                // Hold the beat until it is taken.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (rx_backlog.size() == 0 ||
                         (rx_backlog[0].hold_for_drain && pending_results.size() != 0)) begin
                i_s_tvalid <= 1'b0;
            end else begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= rx_backlog[0].ch;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver: alternates runs of readiness with runs of stalling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            ready_left <= $urandom_range(1, 40);
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            i_m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Monitor: compares every result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction waiting: tdata %h", o_m_tdata);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("match_status", exp_r.status, o_m_tdata[1:0]);
                check_field("conn_id", exp_r.conn_id, o_m_tdata[4:2]);
                check_field("frame_length", exp_r.frame_length, o_m_tdata[20:5]);
                check_field("data_byte", exp_r.data_byte, o_m_tdata[28:21]);
                check_field("data_index", exp_r.data_index, o_m_tdata[37:29]);
                check_field("data_valid", exp_r.data_valid, o_m_tuser);
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** ipd_frame_matcher_core: FAILED **");
            $finish;
        end
    end

endmodule

@@ files.f @@
hdl/ipdm_pkg.sv
hdl/ipdm_parser.sv
hdl/ipd_frame_matcher_core.sv
verif/ipd_frame_matcher_core_tb.sv
